@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the HSV lamp duty controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clock edge while reset is released.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/hldc_pkg.sv @@
// ----------------------------------------------------------------------------
// hldc_pkg
// Types and constants shared by the HSV lamp duty controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hldc_pkg;

  // Command codes carried in cmd_i.
  typedef enum logic [2:0] {
    CMD_POWER  = 3'd0,
    CMD_OFF    = 3'd1,
    CMD_HUE    = 3'd2,
    CMD_SAT    = 3'd3,
    CMD_BRIGHT = 3'd4
  } hldc_cmd_e;

  // Back end conversion sequencer.
  typedef enum logic [2:0] {
    CV_IDLE,
    CV_FRAC,
    CV_TERM,
    CV_PROD,
    CV_QUOT,
    CV_SCALE,
    CV_DIV
  } hldc_conv_state_e;

  // Level snapshot taken by a refreshing command.
  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] sat;
    logic [15:0] bright;
  } hldc_level_t;

  // Front to queue push beat.
  typedef struct packed {
    logic        valid;
    hldc_level_t level;
  } hldc_push_t;

  // Configuration register map.
  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_FULL_SCALE_DUTY = 1'b0;
  localparam logic [15:0] FULL_SCALE_RESET = 16'd8191;

endpackage

`default_nettype wire

@@ sv/hldc_front.sv @@
// ----------------------------------------------------------------------------
// hldc_front
// Command decoder: keeps the lamp state and pushes a level snapshot for
// every command that needs a refresh.
// ----------------------------------------------------------------------------
`default_nettype none

module hldc_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         cmd_i,
  input  wire logic [15:0]        value_i,
  input  wire logic               full_i,
  output hldc_pkg::hldc_push_t    push_o
);

  logic [15:0] hue_q, hue_d;
  logic [15:0] sat_q, sat_d;
  logic [15:0] bright_q, bright_d;
  logic [15:0] saved_q, saved_d;
  logic        on_q, on_d;
  logic        refresh;
  logic        accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    hue_d    = hue_q;
    sat_d    = sat_q;
    bright_d = bright_q;
    saved_d  = saved_q;
    on_d     = on_q;
    refresh  = 1'b0;
    unique case (hldc_pkg::hldc_cmd_e'(cmd_i))
      hldc_pkg::CMD_POWER: begin
        if (value_i[0]) begin
          bright_d = saved_q;
          on_d     = 1'b1;
        end else begin
          saved_d  = bright_q;
          bright_d = '0;
          on_d     = 1'b0;
        end
        refresh = 1'b1;
      end
      hldc_pkg::CMD_OFF: begin
        bright_d = '0;
        on_d     = 1'b0;
        refresh  = 1'b1;
      end
      hldc_pkg::CMD_HUE: begin
        hue_d   = value_i;
        refresh = on_q;
      end
      hldc_pkg::CMD_SAT: begin
        sat_d   = value_i;
        refresh = on_q;
      end
      hldc_pkg::CMD_BRIGHT: begin
        bright_d = value_i;
        saved_d  = value_i;
        refresh  = on_q;
      end
      default: begin
        refresh = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q    <= '0;
      sat_q    <= '0;
      bright_q <= '0;
      saved_q  <= '0;
      on_q     <= 1'b0;
    end else if (accept) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= bright_d;
      saved_q  <= saved_d;
      on_q     <= on_d;
    end
  end

  // Snapshot the updated levels into the queue.
  assign push_o.valid        = accept && refresh;
  assign push_o.level.hue    = hue_d;
  assign push_o.level.sat    = sat_d;
  assign push_o.level.bright = bright_d;

endmodule

`default_nettype wire

@@ sv/hldc_fifo.sv @@
// ----------------------------------------------------------------------------
// hldc_fifo
// Short queue of level snapshots between the decoder and the converter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hldc_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire hldc_pkg::hldc_push_t push_i,
  output logic                      full_o,
  output logic                      valid_o,
  output hldc_pkg::hldc_level_t     level_o,
  input  wire logic                 pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hldc_pkg::hldc_level_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign level_o = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_RST(a_no_push_when_full, clk_i, rst_ni, !(push_i.valid && full_o),
              "snapshot pushed into a full queue")
  `ASSERT_RST(a_count_bound, clk_i, rst_ni, cnt_q <= CntW'(Depth),
              "queue count above depth")

endmodule

`default_nettype wire

@@ sv/hldc_convert.sv @@
// ----------------------------------------------------------------------------
// hldc_convert
// HSV to RGB converter and duty scaler, a seven step sequencer with an
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hldc_convert (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fifo_valid_i,
  input  wire hldc_pkg::hldc_level_t level_i,
  output logic                       pop_o,
  input  wire logic [15:0]           full_scale_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [15:0]                red_duty_o,
  output logic [15:0]                green_duty_o,
  output logic [15:0]                blue_duty_o,
  output logic                       range_error_o
);

  // Reciprocals: x/3 for x < 2048, x/100 for x < 43690 and x < 2^23, x/10000.
  localparam logic [18:0] RecipThree      = 19'd683;
  localparam logic [28:0] RecipHundredLo  = 29'd20972;
  localparam logic [40:0] RecipTenThousand = 41'd1717987;
  localparam logic [46:0] RecipHundredHi  = 47'd10737419;

  hldc_pkg::hldc_conv_state_e state_q, state_d;
  logic load_out;

  logic        err_q;
  logic [2:0]  sx_q;
  logic [5:0]  hr_q;
  logic [6:0]  s_q, v_q;
  logic [6:0]  frac_q;
  logic [13:0] pn_q, qa_q, tb_q;
  logic [6:0]  p_q, q_q, t_q;
  logic [19:0] qn_q, tn_q;
  logic [22:0] rn_q, gn_q, bn_q;
  logic        out_valid_q;

  // Sextant decode of the incoming hue.
  logic [8:0]  hh;
  logic [2:0]  sx;
  logic [8:0]  base;
  logic        err;
  logic [8:0]  hr;

  always_comb begin
    hh = (level_i.hue == 16'd360) ? 9'd0 : level_i.hue[8:0];
    err = (level_i.hue > 16'd360) || (level_i.sat > 16'd100) ||
          (level_i.bright > 16'd100);
    priority if (hh >= 9'd300) begin
      sx = 3'd5; base = 9'd300;
    end else if (hh >= 9'd240) begin
      sx = 3'd4; base = 9'd240;
    end else if (hh >= 9'd180) begin
      sx = 3'd3; base = 9'd180;
    end else if (hh >= 9'd120) begin
      sx = 3'd2; base = 9'd120;
    end else if (hh >= 9'd60) begin
      sx = 3'd1; base = 9'd60;
    end else begin
      sx = 3'd0; base = 9'd0;
    end
    hr = hh - base;
  end

  // Step arithmetic.
  logic [8:0]  hr5;
  logic [18:0] frac_prod;
  logic [28:0] p_prod;
  logic [40:0] q_prod, t_prod;
  logic [6:0]  r_lvl, g_lvl, b_lvl;
  logic [46:0] r_prod, g_prod, b_prod;

  assign hr5       = {3'b0, hr_q} * 9'd5;
  assign frac_prod = 19'(hr5) * RecipThree;
  assign p_prod    = 29'(pn_q) * RecipHundredLo;
  assign q_prod    = 41'(qn_q) * RecipTenThousand;
  assign t_prod    = 41'(tn_q) * RecipTenThousand;
  assign r_prod    = 47'(rn_q) * RecipHundredHi;
  assign g_prod    = 47'(gn_q) * RecipHundredHi;
  assign b_prod    = 47'(bn_q) * RecipHundredHi;

  always_comb begin
    unique case (sx_q)
      3'd0:    begin r_lvl = v_q; g_lvl = t_q; b_lvl = p_q; end
      3'd1:    begin r_lvl = q_q; g_lvl = v_q; b_lvl = p_q; end
      3'd2:    begin r_lvl = p_q; g_lvl = v_q; b_lvl = t_q; end
      3'd3:    begin r_lvl = p_q; g_lvl = q_q; b_lvl = v_q; end
      3'd4:    begin r_lvl = t_q; g_lvl = p_q; b_lvl = v_q; end
      default: begin r_lvl = v_q; g_lvl = p_q; b_lvl = q_q; end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      hldc_pkg::CV_IDLE: begin
        if (fifo_valid_i) begin
          pop_o   = 1'b1;
          state_d = hldc_pkg::CV_FRAC;
        end
      end
      hldc_pkg::CV_FRAC:  state_d = hldc_pkg::CV_TERM;
      hldc_pkg::CV_TERM:  state_d = hldc_pkg::CV_PROD;
      hldc_pkg::CV_PROD:  state_d = hldc_pkg::CV_QUOT;
      hldc_pkg::CV_QUOT:  state_d = hldc_pkg::CV_SCALE;
      hldc_pkg::CV_SCALE: state_d = hldc_pkg::CV_DIV;
      hldc_pkg::CV_DIV: begin
        // Hold the finished beat until the output register frees up.
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = hldc_pkg::CV_IDLE;
        end
      end
      default: state_d = hldc_pkg::CV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hldc_pkg::CV_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      err_q <= err;
      sx_q  <= sx;
      hr_q  <= hr[5:0];
      s_q   <= level_i.sat[6:0];
      v_q   <= level_i.bright[6:0];
    end
    if (state_q == hldc_pkg::CV_FRAC) begin
      frac_q <= frac_prod[17:11];
      pn_q   <= 14'(v_q) * 14'(7'd100 - s_q);
    end
    if (state_q == hldc_pkg::CV_TERM) begin
      qa_q <= 14'd10000 - 14'(frac_q) * 14'(s_q);
      tb_q <= 14'd10000 - 14'(s_q) * 14'(7'd100 - frac_q);
      p_q  <= p_prod[27:21];
    end
    if (state_q == hldc_pkg::CV_PROD) begin
      qn_q <= 20'(v_q) * 20'(qa_q);
      tn_q <= 20'(v_q) * 20'(tb_q);
    end
    if (state_q == hldc_pkg::CV_QUOT) begin
      q_q <= q_prod[40:34];
      t_q <= t_prod[40:34];
    end
    if (state_q == hldc_pkg::CV_SCALE) begin
      rn_q <= 23'(r_lvl) * 23'(full_scale_i);
      gn_q <= 23'(g_lvl) * 23'(full_scale_i);
      bn_q <= 23'(b_lvl) * 23'(full_scale_i);
    end
    if (load_out) begin
      red_duty_o    <= err_q ? 16'd0 : r_prod[45:30];
      green_duty_o  <= err_q ? 16'd0 : g_prod[45:30];
      blue_duty_o   <= err_q ? 16'd0 : b_prod[45:30];
      range_error_o <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_RST(a_err_zero_duty, clk_i, rst_ni,
              (out_valid_o && range_error_o) |->
              (red_duty_o == 16'd0 && green_duty_o == 16'd0 && blue_duty_o == 16'd0),
              "range error beat with nonzero duty")
  `ASSERT_RST(a_pop_has_data, clk_i, rst_ni, pop_o |-> fifo_valid_i,
              "pop from an empty queue")

endmodule

`default_nettype wire

@@ sv/hsv_light_duty_controller_top.sv @@
// ----------------------------------------------------------------------------
// hsv_light_duty_controller_top
// HSV lamp duty controller: command decoder, snapshot queue, HSV to RGB
// converter with duty scaling, and an APB register for the full scale duty.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------
//   in       | in_valid_i / in_ready_o   | cmd_i, value_i
//   out      | out_valid_o / out_ready_i | red/green/blue_duty_o, range_error_o
//   config   | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied 1)
//
// The decoder takes one command a cycle while the queue has room; commands
// that need no refresh complete in that cycle.
// A refresh steps through the converter sequencer (decode, fraction,
// terms, products, quotients, channel scale, duty divide), and the
// converter takes no new snapshot until it has finished the last one.
// The queue holds QueueDepth snapshots, so the decoder stalls only when it is
// full; a finished beat waits in the output register while the next converts.
// Reset clears the lamp state, the queue and the output valid, and loads the
// full scale duty with 8191.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_light_duty_controller_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // command channel
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [2:0]                   cmd_i,
  input  wire logic [15:0]                  value_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [15:0]                       red_duty_o,
  output logic [15:0]                       green_duty_o,
  output logic [15:0]                       blue_duty_o,
  output logic                              range_error_o,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [hldc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // Full scale duty register; writes beyond the map are dropped.
  logic [15:0] full_scale_q;
  logic        cfg_write;
  logic        reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= hldc_pkg::FULL_SCALE_RESET;
    end else if (cfg_write && reg_idx == hldc_pkg::REG_FULL_SCALE_DUTY) begin
      full_scale_q <= pwdata[15:0];
    end
  end

  assign prdata = (reg_idx == hldc_pkg::REG_FULL_SCALE_DUTY) ? {16'd0, full_scale_q} : 32'd0;

  // Front: decode commands, track state, push refresh snapshots.
  hldc_pkg::hldc_push_t  push;
  hldc_pkg::hldc_level_t head_level;
  logic                  queue_full;
  logic                  head_valid;
  logic                  pop;

  hldc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .full_i     (queue_full),
    .push_o     (push)
  );

  // Queue: decouple the decoder from the converter.
  hldc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (queue_full),
    .valid_o (head_valid),
    .level_o (head_level),
    .pop_i   (pop)
  );

  // Back: convert one snapshot at a time and register the result beat.
  hldc_convert u_convert (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_valid_i  (head_valid),
    .level_i       (head_level),
    .pop_o         (pop),
    .full_scale_i  (full_scale_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .red_duty_o    (red_duty_o),
    .green_duty_o  (green_duty_o),
    .blue_duty_o   (blue_duty_o),
    .range_error_o (range_error_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/duty_checker.sv @@
// ----------------------------------------------------------------------------
// duty_checker
// Watches the command, result and configuration channels of the HSV lamp
// duty controller. It keeps its own copy of the lamp state and predicts the
// duty triple of every refreshing command, then compares result beats in order.
// ----------------------------------------------------------------------------
module duty_checker
  import hldc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         cmd_i,
  input  logic [15:0]        value_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [15:0]        red_duty_i,
  input  logic [15:0]        green_duty_i,
  input  logic [15:0]        blue_duty_i,
  input  logic               range_error_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,
  output int                 pending_o,
  output int                 failures_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [PADDR_W-1:0] FULL_SCALE_ADDR = PADDR_W'(4 * REG_FULL_SCALE_DUTY);

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        range_error;
  } duty_set_t;

  logic [15:0] scale_q;
  logic [15:0] hue_q;
  logic [15:0] sat_q;
  logic [15:0] bright_q;
  logic [15:0] saved_q;
  logic        lamp_q;
  duty_set_t   duty_queue[$];

  initial begin
    pending_o  = 0;
    failures_o = 0;
  end

  // Integer-percent HSV to RGB by sextant, then scale each channel to a duty.
  function automatic duty_set_t convert_levels(input logic [15:0] hue, input logic [15:0] sat,
                                               input logic [15:0] bright,
                                               input logic [15:0] scale);
    int unsigned h, s, v, sextant, frac, p, q, t, r, g, b;
    duty_set_t d;
    h = hue;
    s = sat;
    v = bright;
    d = '0;
    if (h > 360 || s > 100 || v > 100) begin
      d.range_error = 1'b1;
      return d;
    end
    if (h == 360) h = 0;
    sextant = h / 60;
    frac    = (100 * h) / 60 - 100 * sextant;
    p = v * (100 - s) / 100;
    q = v * (10000 - frac * s) / 10000;
    t = v * (10000 - s * (100 - frac)) / 10000;
    case (sextant)
      0:       begin r = v; g = t; b = p; end
      1:       begin r = q; g = v; b = p; end
      2:       begin r = p; g = v; b = t; end
      3:       begin r = p; g = q; b = v; end
      4:       begin r = t; g = p; b = v; end
      default: begin r = v; g = p; b = q; end
    endcase
    d.red   = 16'((r * scale) / 100);
    d.green = 16'((g * scale) / 100);
    d.blue  = 16'((b * scale) / 100);
    return d;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    duty_set_t got;
    duty_set_t want;
    logic      refresh;
    if (!rst_ni) begin
      scale_q   = FULL_SCALE_RESET;
      hue_q     = '0;
      sat_q     = '0;
      bright_q  = '0;
      saved_q   = '0;
      lamp_q    = 1'b0;
      duty_queue.delete();
      pending_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == FULL_SCALE_ADDR)
        scale_q = pwdata_i[15:0];

      // Retire the oldest expectation first; a same-edge command cannot match itself.
      if (out_valid_i && out_ready_i) begin
        got = {red_duty_i, green_duty_i, blue_duty_i, range_error_i};
        if (duty_queue.size() == 0) begin
          $error("result beat with no expectation: red %0d green %0d blue %0d error %0b",
                 got.red, got.green, got.blue, got.range_error);
          failures_o++;
        end else begin
          want = duty_queue.pop_front();
          check_field("red_duty", want.red, got.red);
          check_field("green_duty", want.green, got.green);
          check_field("blue_duty", want.blue, got.blue);
          check_field("range_error", want.range_error, got.range_error);
        end
      end

      if (in_valid_i && in_ready_i) begin
        refresh = 1'b0;
        case (cmd_i)
          CMD_POWER: begin
            if (value_i[0]) begin
              bright_q = saved_q;
              lamp_q   = 1'b1;
            end else begin
              saved_q  = bright_q;
              bright_q = '0;
              lamp_q   = 1'b0;
            end
            refresh = 1'b1;
          end
          CMD_OFF: begin
            bright_q = '0;
            lamp_q   = 1'b0;
            refresh  = 1'b1;
          end
          CMD_HUE: begin
            hue_q   = value_i;
            refresh = lamp_q;
          end
          CMD_SAT: begin
            sat_q   = value_i;
            refresh = lamp_q;
          end
          CMD_BRIGHT: begin
            bright_q = value_i;
            saved_q  = value_i;
            refresh  = lamp_q;
          end
          default: ;
        endcase
        if (refresh) duty_queue.push_back(convert_levels(hue_q, sat_q, bright_q, scale_q));
      end
      pending_o = duty_queue.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the HSV lamp duty controller. A directed opening
// hits every command, every hue sextant, the hue wrap and the range errors;
// random phases then run under several full scale duty settings with random
// idling on both channels bar one setting; duty_checker predicts and checks.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hldc_pkg::*;

  // Generous bound for ~1300 beats plus drain pauses.
  localparam int unsigned CYCLE_LIMIT     = 400000;
  // Settle time after the last expected beat.
  localparam int unsigned DRAIN_CYCLES    = 32;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned IDLE_PERCENT    = 11;

  // Command codes the decoder ignores.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  localparam logic [PADDR_W-1:0] FULL_SCALE_ADDR = PADDR_W'(4 * REG_FULL_SCALE_DUTY);

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [2:0]         cmd_i       = '0;
  logic [15:0]        value_i     = '0;
  logic               out_ready_i = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [31:0]        pwdata      = '0;

  logic               in_ready_o;
  logic               out_valid_o;
  logic [15:0]        red_duty_o;
  logic [15:0]        green_duty_o;
  logic [15:0]        blue_duty_o;
  logic               range_error_o;
  logic [31:0]        prdata;
  logic               pready;

  int                 pending_beats;
  int                 failures;
  int unsigned        cycle_count = 0;
  // Clear to run a stretch with no idling on either side.
  logic               idle_on     = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hsv_light_duty_controller_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_duty_o   (red_duty_o),
    .green_duty_o (green_duty_o),
    .blue_duty_o  (blue_duty_o),
    .range_error_o(range_error_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  duty_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_duty_i   (red_duty_o),
    .green_duty_i (green_duty_o),
    .blue_duty_i  (blue_duty_o),
    .range_error_i(range_error_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .pending_o    (pending_beats),
    .failures_o   (failures)
  );

  // Stall the result channel at random; ready may drop at any time.
  always @(negedge clk_i) begin
    out_ready_i = !idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Watchdog: end the run if the design hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Present one command beat and hold it until the handshake completes.
  // Drive at the falling edge, sample ready at the rising edge.
  task automatic send_beat(input logic [2:0] cmd, input logic [15:0] value);
    @(negedge clk_i);
    while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i      = cmd;
    value_i    = value;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and hold off until every predicted result beat has arrived.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_beats != 0) @(negedge clk_i);
  endtask

  // Write the full scale duty while the block is idle: drain, let any
  // command still in the pipe settle, then run a setup and an access cycle.
  task automatic write_full_scale(input logic [15:0] scale);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = FULL_SCALE_ADDR;
    pwdata  = {16'h0000, scale};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // One random phase. Most beats are legal commands with in-range levels so
  // the lamp spends most of its time on and refreshing; the rest is noise:
  // raw 16-bit operands, out-of-range levels and ignored command codes.
  task automatic run_random_phase(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    logic [2:0]  cmd;
    logic [15:0] value;
    sent = 0;
    while (sent < count) begin
      pick  = $urandom_range(0, 99);
      value = 16'($urandom());
      if (pick < 6) begin
        cmd = CMD_POWER;
        // bias toward power-on so setters keep producing beats
        value[0] = ($urandom_range(0, 99) < 70);
      end else if (pick < 8) begin
        cmd = CMD_OFF;
      end else if (pick < 36) begin
        cmd  = CMD_HUE;
        pick = $urandom_range(0, 99);
        if (pick < 85) value = 16'($urandom_range(0, 360));
        else if (pick < 90) value = 16'd360;
      end else if (pick < 64) begin
        cmd = CMD_SAT;
        if ($urandom_range(0, 99) < 90) value = 16'($urandom_range(0, 100));
      end else if (pick < 92) begin
        cmd = CMD_BRIGHT;
        if ($urandom_range(0, 99) < 90) value = 16'($urandom_range(0, 100));
      end else if (pick < 96) begin
        cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      end else begin
        cmd = 3'($urandom_range(CMD_POWER, CMD_BRIGHT));
      end
      send_beat(cmd, value);
      if (cmd < CMD_UNUSED_LO) sent++;
      // now and then let the result side empty out completely
      if ($urandom_range(0, 149) == 0) wait_drained();
    end
  endtask

  initial begin
    logic [15:0] scales[5];
    scales = '{16'd0, 16'hFFFF, 16'd1, 16'd100, 16'($urandom())};

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Setters while off: state changes, no beat.
    send_beat(CMD_SAT, 16'd0);
    send_beat(CMD_HUE, 16'd0);
    send_beat(CMD_BRIGHT, 16'd100);
    // Power on restores the saved brightness: full white.
    send_beat(CMD_POWER, 16'h0001);
    // Hue at the wrap point reads as zero, then walk every sextant.
    send_beat(CMD_SAT, 16'd100);
    send_beat(CMD_HUE, 16'd360);
    send_beat(CMD_HUE, 16'd60);
    send_beat(CMD_HUE, 16'd120);
    send_beat(CMD_HUE, 16'd180);
    send_beat(CMD_HUE, 16'd240);
    send_beat(CMD_HUE, 16'd300);
    send_beat(CMD_HUE, 16'd359);
    send_beat(CMD_SAT, 16'd50);
    send_beat(CMD_BRIGHT, 16'd0);
    // Out-of-range levels raise the error flag.
    send_beat(CMD_HUE, 16'd361);
    send_beat(CMD_HUE, 16'hFFFF);
    send_beat(CMD_HUE, 16'd200);
    send_beat(CMD_SAT, 16'd101);
    send_beat(CMD_SAT, 16'd100);
    send_beat(CMD_BRIGHT, 16'hFFFF);
    send_beat(CMD_BRIGHT, 16'd100);
    // Power off with upper operand bits set: only bit 0 counts.
    send_beat(CMD_POWER, 16'hFFFE);
    send_beat(CMD_POWER, 16'h0001);
    // Force off keeps the saved brightness for the next power on.
    send_beat(CMD_OFF, 16'hFFFF);
    send_beat(CMD_POWER, 16'hFFFF);
    // Ignored codes: no state change, no beat.
    send_beat(CMD_UNUSED_LO, 16'hFFFF);
    send_beat(CMD_UNUSED_HI, 16'h0000);

    run_random_phase(ITEMS_PER_PHASE);
    foreach (scales[i]) begin
      write_full_scale(scales[i]);
      // run the second setting with no idling at all
      idle_on = (i != 1);
      run_random_phase(ITEMS_PER_PHASE);
    end
    idle_on = 1'b1;

    // Drain and give any stray beat time to show up.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/hldc_pkg.sv
sv/hldc_front.sv
sv/hldc_fifo.sv
sv/hldc_convert.sv
sv/hsv_light_duty_controller_top.sv
tb/sv/duty_checker.sv
tb/sv/testbench.sv
